[design/ale_pkg.sv]
// shared types and constants for the array list engine
// depends on nothing; imported by ale_ctrl and array_list_engine
`default_nettype none

package ale_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_DELETE   = 2'd1;
    localparam logic [1:0] KIND_LOCATE   = 2'd2;
    localparam logic [1:0] KIND_RETRIEVE = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RANGE  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [POS_W-1:0]        found_position;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        length;
    } res_t;

endpackage

`default_nettype wire

[design/ale_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/ale_ctrl.sv]
// sequencer and shared index/compare unit of the array list engine
// depends on ale_pkg and ale_ram
`default_nettype none

module ale_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire ale_pkg::req_t req,
    output logic               idle,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ale_pkg::res_t      res
);
    import ale_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_DEL  = 3'd2;
    localparam logic [2:0] ST_LOC  = 3'd3;
    localparam logic [2:0] ST_RET  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    req_t              req_reg, req_next;
    res_t              res_reg, res_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic [VAL_W-1:0]  rdata;

    // shared compare unit operands
    logic [CMP_W-1:0]  cnt_x, idx_x, pos_x, in_pos_x;
    logic              hit;

    ale_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign cnt_x    = CMP_W'(cnt_reg);
    assign idx_x    = CMP_W'(idx_reg);
    assign pos_x    = CMP_W'(req_reg.position);
    assign in_pos_x = CMP_W'(req.position);
    assign hit      = pend_reg && (rdata == req_reg.value);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rdata;
        raddr          = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next                = req;
                    res_next.status         = STAT_OK;
                    res_next.found_position = req.position;
                    res_next.read_value     = '0;
                    res_next.length         = POS_W'(cnt_reg);
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (in_pos_x > cnt_x)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_FIN;
                            end
                            else if (cnt_x == CMP_W'(CAPACITY))
                            begin
                                res_next.status = STAT_FULL;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = ST_INS;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (in_pos_x >= cnt_x)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(req.position) + CNT_W'(1);
                                state_next = ST_DEL;
                            end
                        end
                        KIND_LOCATE:
                        begin
                            idx_next   = '0;
                            state_next = ST_LOC;
                        end
                        default:
                        begin
                            if (in_pos_x >= cnt_x)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                raddr      = ADDR_W'(req.position);
                                state_next = ST_RET;
                            end
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                // shift up from the tail: read i-1, write it to i next cycle
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (idx_x > pos_x)
                begin
                    raddr          = ADDR_W'(idx_reg - CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(idx_reg);
                    idx_next       = idx_reg - CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    we              = 1'b1;
                    waddr           = ADDR_W'(req_reg.position);
                    wdata           = req_reg.value;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    res_next.length = POS_W'(cnt_reg + CNT_W'(1));
                    state_next      = ST_FIN;
                end
            end
            ST_DEL:
            begin
                // shift down: read i, write it to i-1 next cycle
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (idx_reg < cnt_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(idx_reg - CNT_W'(1));
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_next        = cnt_reg - CNT_W'(1);
                    res_next.length = POS_W'(cnt_reg - CNT_W'(1));
                    state_next      = ST_FIN;
                end
            end
            ST_LOC:
            begin
                if (hit)
                begin
                    res_next.status         = STAT_OK;
                    res_next.found_position = POS_W'(pend_addr_reg);
                    state_next              = ST_FIN;
                end
                else if (idx_reg < cnt_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else
                begin
                    res_next.status         = STAT_ABSENT;
                    res_next.found_position = POS_W'(cnt_reg);
                    state_next              = ST_FIN;
                end
            end
            ST_RET:
            begin
                res_next.read_value = rdata;
                state_next          = ST_FIN;
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        req_reg       <= req_next;
        res_reg       <= res_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FIN) |-> !we)
        else $error("ram write outside a shift");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ($past(state_reg) == ST_INS || $past(state_reg) == ST_DEL))
        else $error("count changed outside insert or delete");

    a_loc_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOC && pend_reg) |-> (CNT_W'(pend_addr_reg) < cnt_reg))
        else $error("locate compared an entry past the end");

endmodule

`default_nettype wire

[design/array_list_engine.sv]
// Array list engine: an ordered list of up to 16 signed 32-bit words kept in a
// small ram plus a length. One request is taken at a time; s_tready is low
// while it runs. Insert shifts the entries from position p up and writes the
// new word, delete shifts the entries above p down, locate compares entries
// from the head until a match or the end, retrieve reads one entry, and an
// error is answered without a ram access; each result then goes to the output
// register. The single ram port pair moves or compares one entry per cycle.
// The output register lets a result wait for m_tready while the next request
// is already being worked on.
// top level; depends on ale_pkg and ale_ctrl
`default_nettype none

module array_list_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position[4:0], value[36:5], zero fill
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // status[1:0], found_position[6:2],
                                        // read_value[38:7], length[43:39], zero fill
);
    import ale_pkg::*;

    req_t  req;
    res_t  res;
    logic  idle;
    logic  res_valid;
    logic  res_ready;
    logic  m_tvalid_reg, m_tvalid_next;
    res_t  out_reg, out_next;

    assign req.kind     = s_tuser;
    assign req.position = s_tdata[POS_W-1:0];
    assign req.value    = s_tdata[POS_W+VAL_W-1:POS_W];

    assign s_tready  = idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req      (req),
        .idle     (idle),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_reg.length, out_reg.read_value,
                       out_reg.found_position, out_reg.status};

endmodule

`default_nettype wire
